@@ sv/ray_sphere_intersect_macros.svh @@
// Assertion macros shared by the ray / sphere intersection block.
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// same-cycle implication, quiet during reset
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define RSI_ASSERT_NXT_ND(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rsi_pkg.sv @@
// Widths, types and constants of the ray / sphere intersection pipeline.
package rsi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CW    = 32;              // coordinate width
    localparam int RW    = 31;              // radius width
    localparam int VW    = CW + 1;          // O - C
    localparam int DDW   = 2 * CW - 1;      // D*D, non-negative
    localparam int DVPW  = CW + VW;         // D*V, signed
    localparam int VVW   = 2 * VW - 1;      // V*V, non-negative
    localparam int RRW   = 2 * RW;          // R*R
    localparam int AW    = 2 * CW;          // a = D.D
    localparam int HW    = DVPW + 2;        // h = D.V, signed
    localparam int HMW   = HW - 1;          // |h|
    localparam int CCW   = VVW + 3;         // c = V.V - R*R, signed
    localparam int CMW   = CCW - 1;         // |c|
    localparam int BW    = HW + 1;          // b = 2h, signed

    localparam int HLO   = (HMW + 1) / 2;
    localparam int HHI   = HMW - HLO;
    localparam int ALO   = AW / 2;
    localparam int AHI   = AW - ALO;
    localparam int CLO   = (CMW + 1) / 2;
    localparam int CHI   = CMW - CLO;

    localparam int PW    = (2 * HMW > AW + CMW) ? 2 * HMW : AW + CMW;
    localparam int EW    = PW + 2;          // h*h - a*c, signed
    localparam int DW    = EW + 2;          // disc = 4e
    localparam int RTW   = (DW + 1) / 2;    // root width
    localparam int RMW   = RTW + 3;         // sqrt remainder

    localparam int NW    = ((BW > RTW) ? BW : RTW) + 2;   // root numerators, signed
    localparam int NMW   = NW - 1;
    localparam int NUMW  = NMW + FRAC_BITS;
    localparam int DENW  = AW + 1;          // 2a
    localparam int QW    = CW - 1;          // quotient bits
    localparam int DIVW  = ((NUMW > DENW + QW) ? NUMW : DENW + QW) + 1;

    localparam logic [CW-1:0] T_MAX = {1'b0, {(CW - 1){1'b1}}};

    typedef struct packed {
        logic en;
        logic vld;
    } t_ctl;

    typedef struct packed {
        logic                  miss;
        logic [AW-1:0]         a;
        logic signed [BW-1:0]  b;
        logic signed [CW-1:0]  best;
    } t_side;

endpackage

@@ sv/rsi_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, with sideband data.
module rsi_sqrt_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsi_pkg::t_ctl                 i_ctl,
    input  logic [2*rsi_pkg::RTW-1:0]     i_rad,
    input  rsi_pkg::t_side                i_side,
    output logic                          o_vld,
    output logic [rsi_pkg::RTW-1:0]       o_root,
    output rsi_pkg::t_side                o_side
);

    logic                          r_vld  [rsi_pkg::RTW];
    logic [2*rsi_pkg::RTW-1:0]     r_rad  [rsi_pkg::RTW];
    logic [rsi_pkg::RMW-1:0]       r_rem  [rsi_pkg::RTW];
    logic [rsi_pkg::RTW-1:0]       r_root [rsi_pkg::RTW];
    rsi_pkg::t_side                r_side [rsi_pkg::RTW];

    for (genvar g = 0; g < rsi_pkg::RTW; g++) begin : g_stage
        logic                      p_vld;
        logic [2*rsi_pkg::RTW-1:0] p_rad;
        logic [rsi_pkg::RMW-1:0]   p_rem;
        logic [rsi_pkg::RTW-1:0]   p_root;
        rsi_pkg::t_side            p_side;
        logic [rsi_pkg::RMW-1:0]   n_cat;
        logic [rsi_pkg::RMW-1:0]   n_trial;
        logic                      n_ge;

        if (g == 0) begin : g_first
            assign p_vld  = i_ctl.vld;
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_side = r_side[g-1];
        end

        // bring down two radicand bits, try (root << 2) | 1
        assign n_cat   = {p_rem[rsi_pkg::RMW-3:0], p_rad[2*rsi_pkg::RTW-1 -: 2]};
        assign n_trial = {{(rsi_pkg::RMW - rsi_pkg::RTW - 2){1'b0}}, p_root, 2'b01};
        assign n_ge    = n_cat >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g] <= p_vld;
            end
            if (i_ctl.en) begin
                r_rad[g]  <= {p_rad[2*rsi_pkg::RTW-3:0], 2'b00};
                r_rem[g]  <= n_ge ? n_cat - n_trial : n_cat;
                r_root[g] <= {p_root[rsi_pkg::RTW-2:0], n_ge};
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[rsi_pkg::RTW-1];
    assign o_root = r_root[rsi_pkg::RTW-1];
    assign o_side = r_side[rsi_pkg::RTW-1];

endmodule

@@ sv/ray_sphere_intersect.sv @@
// Top level: pipelined ray / sphere hit test on signed Q16.16 values.
//
// Request channel: i_in_valid / o_in_ready carry one ray, one sphere and the
// closest distance found so far. Result channel: o_out_valid / i_out_ready
// carry o_hit and o_new_best_dist (the old best on a miss).
// The pipeline takes one request per cycle and gives one result per cycle
// while results are taken. It holds 7 stages of products and sums (the h*h and
// a*c multiplies cut into partial products of 32- to 34-bit halves), 68 stages
// of the square root (one root bit per stage), a root-select and a saturate
// stage, 31 stages of the divider (one quotient bit per stage) and the output
// register. The square root over the 136-bit discriminant sets the depth.
// Reset clears every stage valid bit; data registers are not reset.
// When the result is not taken, the whole pipeline holds (o_in_ready low)
// and resumes with nothing lost or repeated once i_out_ready returns.
`include "ray_sphere_intersect_macros.svh"

module ray_sphere_intersect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [rsi_pkg::CW-1:0]     i_origin_x,
    input  logic signed [rsi_pkg::CW-1:0]     i_origin_y,
    input  logic signed [rsi_pkg::CW-1:0]     i_origin_z,
    input  logic signed [rsi_pkg::CW-1:0]     i_dir_x,
    input  logic signed [rsi_pkg::CW-1:0]     i_dir_y,
    input  logic signed [rsi_pkg::CW-1:0]     i_dir_z,
    input  logic signed [rsi_pkg::CW-1:0]     i_center_x,
    input  logic signed [rsi_pkg::CW-1:0]     i_center_y,
    input  logic signed [rsi_pkg::CW-1:0]     i_center_z,
    input  logic [rsi_pkg::RW-1:0]            i_radius,
    input  logic signed [rsi_pkg::CW-1:0]     i_best_dist,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic signed [rsi_pkg::CW-1:0]     o_new_best_dist
);

    logic w_en;

    // stage 1: V = O - C
    logic signed [rsi_pkg::CW-1:0]   w_org [3];
    logic signed [rsi_pkg::CW-1:0]   w_ctr [3];
    logic signed [rsi_pkg::CW-1:0]   w_dir [3];
    logic                            r1_vld;
    logic signed [rsi_pkg::VW-1:0]   r1_v [3];
    logic signed [rsi_pkg::CW-1:0]   r1_d [3];
    logic [rsi_pkg::RW-1:0]          r1_rad;
    logic signed [rsi_pkg::CW-1:0]   r1_best;

    // stage 2: products
    logic signed [2*rsi_pkg::CW-1:0] n_dd [3];
    logic signed [rsi_pkg::DVPW-1:0] n_dv [3];
    logic signed [2*rsi_pkg::VW-1:0] n_vv [3];
    logic                            r2_vld;
    logic [rsi_pkg::DDW-1:0]         r2_dd [3];
    logic signed [rsi_pkg::DVPW-1:0] r2_dv [3];
    logic [rsi_pkg::VVW-1:0]         r2_vv [3];
    logic [rsi_pkg::RRW-1:0]         r2_rr;
    logic signed [rsi_pkg::CW-1:0]   r2_best;

    // stage 3: a, h, c
    logic                            r3_vld;
    logic [rsi_pkg::AW-1:0]          r3_a;
    logic signed [rsi_pkg::HW-1:0]   r3_h;
    logic [rsi_pkg::CCW-1:0]         r3_c;
    logic signed [rsi_pkg::CW-1:0]   r3_best;

    // stage 4: magnitudes
    logic [rsi_pkg::HW-1:0]          n_hneg;
    logic [rsi_pkg::CCW-1:0]         n_cneg;
    logic                            r4_vld;
    logic [rsi_pkg::HMW-1:0]         r4_hm;
    logic [rsi_pkg::CMW-1:0]         r4_cm;
    logic                            r4_cneg;
    logic                            r4_az;
    logic [rsi_pkg::AW-1:0]          r4_a;
    logic signed [rsi_pkg::BW-1:0]   r4_b;
    logic signed [rsi_pkg::CW-1:0]   r4_best;

    // stage 5: partial products
    logic                                  r5_vld;
    logic [2*rsi_pkg::HLO-1:0]             r5_hll;
    logic [rsi_pkg::HLO+rsi_pkg::HHI-1:0]  r5_hlh;
    logic [2*rsi_pkg::HHI-1:0]             r5_hhh;
    logic [rsi_pkg::ALO+rsi_pkg::CLO-1:0]  r5_alcl;
    logic [rsi_pkg::ALO+rsi_pkg::CHI-1:0]  r5_alch;
    logic [rsi_pkg::AHI+rsi_pkg::CLO-1:0]  r5_ahcl;
    logic [rsi_pkg::AHI+rsi_pkg::CHI-1:0]  r5_ahch;
    logic                                  r5_cneg;
    logic                                  r5_az;
    logic [rsi_pkg::AW-1:0]                r5_a;
    logic signed [rsi_pkg::BW-1:0]         r5_b;
    logic signed [rsi_pkg::CW-1:0]         r5_best;

    // stage 6: h*h and |a*c|
    logic                            r6_vld;
    logic [rsi_pkg::PW-1:0]          r6_h2;
    logic [rsi_pkg::PW-1:0]          r6_ac;
    logic                            r6_cneg;
    logic                            r6_az;
    logic [rsi_pkg::AW-1:0]          r6_a;
    logic signed [rsi_pkg::BW-1:0]   r6_b;
    logic signed [rsi_pkg::CW-1:0]   r6_best;

    // stage 7: discriminant
    logic [rsi_pkg::EW-1:0]          n_e;
    logic [rsi_pkg::DW-1:0]          n_disc;
    logic                            r7_vld;
    logic [2*rsi_pkg::RTW-1:0]       r7_rad;
    rsi_pkg::t_side                  r7_side;

    // square root
    rsi_pkg::t_ctl                   w_sq_ctl;
    logic                            w_sq_vld;
    logic [rsi_pkg::RTW-1:0]         w_sq_root;
    rsi_pkg::t_side                  w_sq_side;

    // stage 8: root select
    logic [rsi_pkg::NW-1:0]          n_rootx;
    logic [rsi_pkg::NW-1:0]          n_bx;
    logic [rsi_pkg::NW-1:0]          n_n1;
    logic [rsi_pkg::NW-1:0]          n_n2;
    logic                            r8_vld;
    logic [rsi_pkg::NMW-1:0]         r8_n;
    logic                            r8_miss;
    logic [rsi_pkg::AW-1:0]          r8_a;
    logic signed [rsi_pkg::CW-1:0]   r8_best;

    // stage 9: divider setup and saturation
    logic [rsi_pkg::DIVW-1:0]        n_num;
    logic [rsi_pkg::DENW-1:0]        n_den;
    logic                            r9_vld;
    logic [rsi_pkg::DIVW-1:0]        r9_num;
    logic [rsi_pkg::DENW-1:0]        r9_den;
    logic                            r9_sat;
    logic                            r9_miss;
    logic signed [rsi_pkg::CW-1:0]   r9_best;

    // divider stages
    logic                            r_dvld [rsi_pkg::QW];
    logic [rsi_pkg::DIVW-1:0]        r_dnum [rsi_pkg::QW];
    logic [rsi_pkg::DENW-1:0]        r_dden [rsi_pkg::QW];
    logic [rsi_pkg::QW-1:0]          r_dq   [rsi_pkg::QW];
    logic                            r_dsat [rsi_pkg::QW];
    logic                            r_dmiss[rsi_pkg::QW];
    logic signed [rsi_pkg::CW-1:0]   r_dbest[rsi_pkg::QW];

    // output
    logic [rsi_pkg::CW-1:0]          n_t;
    logic                            n_hit;
    logic                            r_o_vld;
    logic                            r_o_hit;
    logic signed [rsi_pkg::CW-1:0]   r_o_dist;

    assign w_en       = !r_o_vld || i_out_ready;
    assign o_in_ready = w_en;

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_ctr[0] = i_center_x;
    assign w_ctr[1] = i_center_y;
    assign w_ctr[2] = i_center_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dd[i] = r1_d[i] * r1_d[i];
            n_dv[i] = r1_d[i] * r1_v[i];
            n_vv[i] = r1_v[i] * r1_v[i];
        end
    end

    assign n_hneg = -r3_h;
    assign n_cneg = -r3_c;

    assign n_e    = r6_cneg ? rsi_pkg::EW'(r6_h2) + rsi_pkg::EW'(r6_ac)
                            : rsi_pkg::EW'(r6_h2) - rsi_pkg::EW'(r6_ac);
    assign n_disc = {n_e, 2'b00};

    assign w_sq_ctl = '{en: w_en, vld: r7_vld};

    rsi_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_rad   (r7_rad),
        .i_side  (r7_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // N1 = s - b, N2 = -b - s
    assign n_rootx = {{(rsi_pkg::NW - rsi_pkg::RTW){1'b0}}, w_sq_root};
    assign n_bx    = {{(rsi_pkg::NW - rsi_pkg::BW){w_sq_side.b[rsi_pkg::BW-1]}}, w_sq_side.b};
    assign n_n1    = n_rootx - n_bx;
    assign n_n2    = (~n_bx + rsi_pkg::NW'(1)) - n_rootx;

    assign n_num = rsi_pkg::DIVW'({r8_n, {rsi_pkg::FRAC_BITS{1'b0}}});
    assign n_den = {r8_a, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld  <= i_in_valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= w_sq_vld;
            r9_vld  <= r8_vld;
            r_o_vld <= r_dvld[rsi_pkg::QW-1];
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i]  <= {w_org[i][rsi_pkg::CW-1], w_org[i]}
                          - {w_ctr[i][rsi_pkg::CW-1], w_ctr[i]};
                r1_d[i]  <= w_dir[i];
                r2_dd[i] <= n_dd[i][rsi_pkg::DDW-1:0];
                r2_dv[i] <= n_dv[i];
                r2_vv[i] <= n_vv[i][rsi_pkg::VVW-1:0];
            end
            r1_rad  <= i_radius;
            r1_best <= i_best_dist;

            r2_rr   <= r1_rad * r1_rad;
            r2_best <= r1_best;

            r3_a    <= rsi_pkg::AW'(r2_dd[0]) + rsi_pkg::AW'(r2_dd[1])
                     + rsi_pkg::AW'(r2_dd[2]);
            r3_h    <= rsi_pkg::HW'(r2_dv[0]) + rsi_pkg::HW'(r2_dv[1])
                     + rsi_pkg::HW'(r2_dv[2]);
            r3_c    <= rsi_pkg::CCW'(r2_vv[0]) + rsi_pkg::CCW'(r2_vv[1])
                     + rsi_pkg::CCW'(r2_vv[2]) - rsi_pkg::CCW'(r2_rr);
            r3_best <= r2_best;

            r4_hm   <= r3_h[rsi_pkg::HW-1] ? n_hneg[rsi_pkg::HMW-1:0]
                                           : r3_h[rsi_pkg::HMW-1:0];
            r4_cm   <= r3_c[rsi_pkg::CCW-1] ? n_cneg[rsi_pkg::CMW-1:0]
                                            : r3_c[rsi_pkg::CMW-1:0];
            r4_cneg <= r3_c[rsi_pkg::CCW-1];
            r4_az   <= r3_a == '0;
            r4_a    <= r3_a;
            r4_b    <= {r3_h, 1'b0};
            r4_best <= r3_best;

            r5_hll  <= r4_hm[rsi_pkg::HLO-1:0] * r4_hm[rsi_pkg::HLO-1:0];
            r5_hlh  <= r4_hm[rsi_pkg::HLO-1:0] * r4_hm[rsi_pkg::HMW-1:rsi_pkg::HLO];
            r5_hhh  <= r4_hm[rsi_pkg::HMW-1:rsi_pkg::HLO] * r4_hm[rsi_pkg::HMW-1:rsi_pkg::HLO];
            r5_alcl <= r4_a[rsi_pkg::ALO-1:0] * r4_cm[rsi_pkg::CLO-1:0];
            r5_alch <= r4_a[rsi_pkg::ALO-1:0] * r4_cm[rsi_pkg::CMW-1:rsi_pkg::CLO];
            r5_ahcl <= r4_a[rsi_pkg::AW-1:rsi_pkg::ALO] * r4_cm[rsi_pkg::CLO-1:0];
            r5_ahch <= r4_a[rsi_pkg::AW-1:rsi_pkg::ALO] * r4_cm[rsi_pkg::CMW-1:rsi_pkg::CLO];
            r5_cneg <= r4_cneg;
            r5_az   <= r4_az;
            r5_a    <= r4_a;
            r5_b    <= r4_b;
            r5_best <= r4_best;

            r6_h2   <= (rsi_pkg::PW'(r5_hhh) << (2 * rsi_pkg::HLO))
                     + (rsi_pkg::PW'(r5_hlh) << (rsi_pkg::HLO + 1))
                     + rsi_pkg::PW'(r5_hll);
            r6_ac   <= (rsi_pkg::PW'(r5_ahch) << (rsi_pkg::ALO + rsi_pkg::CLO))
                     + (rsi_pkg::PW'(r5_ahcl) << rsi_pkg::ALO)
                     + (rsi_pkg::PW'(r5_alch) << rsi_pkg::CLO)
                     + rsi_pkg::PW'(r5_alcl);
            r6_cneg <= r5_cneg;
            r6_az   <= r5_az;
            r6_a    <= r5_a;
            r6_b    <= r5_b;
            r6_best <= r5_best;

            r7_rad       <= (2 * rsi_pkg::RTW)'(n_disc);
            r7_side.miss <= r6_az || n_e[rsi_pkg::EW-1];
            r7_side.a    <= r6_a;
            r7_side.b    <= r6_b;
            r7_side.best <= r6_best;

            r8_n    <= n_n2[rsi_pkg::NW-1] ? n_n1[rsi_pkg::NMW-1:0] : n_n2[rsi_pkg::NMW-1:0];
            r8_miss <= w_sq_side.miss || n_n1[rsi_pkg::NW-1];
            r8_a    <= w_sq_side.a;
            r8_best <= w_sq_side.best;

            r9_num  <= n_num;
            r9_den  <= n_den;
            r9_sat  <= n_num >= (rsi_pkg::DIVW'(n_den) << rsi_pkg::QW);
            r9_miss <= r8_miss;
            r9_best <= r8_best;

            r_o_hit  <= n_hit;
            r_o_dist <= n_hit ? n_t : r_dbest[rsi_pkg::QW-1];
        end
    end

    // restoring divider, quotient MSB first
    for (genvar k = 0; k < rsi_pkg::QW; k++) begin : g_div
        logic                          p_vld;
        logic [rsi_pkg::DIVW-1:0]      p_num;
        logic [rsi_pkg::DENW-1:0]      p_den;
        logic [rsi_pkg::QW-1:0]        p_q;
        logic                          p_sat;
        logic                          p_miss;
        logic signed [rsi_pkg::CW-1:0] p_best;
        logic [rsi_pkg::DIVW-1:0]      n_part;
        logic                          n_ge;

        if (k == 0) begin : g_first
            assign p_vld  = r9_vld;
            assign p_num  = r9_num;
            assign p_den  = r9_den;
            assign p_q    = '0;
            assign p_sat  = r9_sat;
            assign p_miss = r9_miss;
            assign p_best = r9_best;
        end else begin : g_next
            assign p_vld  = r_dvld[k-1];
            assign p_num  = r_dnum[k-1];
            assign p_den  = r_dden[k-1];
            assign p_q    = r_dq[k-1];
            assign p_sat  = r_dsat[k-1];
            assign p_miss = r_dmiss[k-1];
            assign p_best = r_dbest[k-1];
        end

        assign n_part = rsi_pkg::DIVW'(p_den) << (rsi_pkg::QW - 1 - k);
        assign n_ge   = p_num >= n_part;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[k] <= 1'b0;
            end else if (w_en) begin
                r_dvld[k] <= p_vld;
            end
            if (w_en) begin
                r_dnum[k]  <= n_ge ? p_num - n_part : p_num;
                r_dden[k]  <= p_den;
                r_dq[k]    <= {p_q[rsi_pkg::QW-2:0], n_ge};
                r_dsat[k]  <= p_sat;
                r_dmiss[k] <= p_miss;
                r_dbest[k] <= p_best;
            end
        end
    end

    assign n_t   = r_dsat[rsi_pkg::QW-1] ? rsi_pkg::T_MAX : {1'b0, r_dq[rsi_pkg::QW-1]};
    assign n_hit = !r_dmiss[rsi_pkg::QW-1] && ($signed(n_t) < r_dbest[rsi_pkg::QW-1]);

    assign o_out_valid     = r_o_vld;
    assign o_hit           = r_o_hit;
    assign o_new_best_dist = r_o_dist;

    `RSI_ASSERT_IMP(a_hit_nonneg, r_o_vld && r_o_hit, !r_o_dist[rsi_pkg::CW-1], "hit with negative distance")
    `RSI_ASSERT_NXT(a_stall_hold, !w_en, $stable(r9_vld) && $stable(r_o_vld) && $stable(r1_vld), "pipeline moved while stalled")
    `RSI_ASSERT_NXT_ND(a_reset_clear, !i_rst_n, !r_o_vld && !r1_vld && !r9_vld, "valid bit set after reset")

endmodule
